@@ rtl/csrspmv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared constants and types for the scaled CSR sparse matrix-vector update.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

    localparam int VEC_DEPTH = 4096;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int FRAC_BITS = 24;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int POS_W  = 12;
    localparam int ROW_W  = 16;
    localparam int FUNC_W = 2;

    localparam int VAL_LSB     = POS_W;
    localparam int OLD_LSB     = POS_W + DATA_W;
    localparam int S_PAYLOAD_W = POS_W + 2 * DATA_W;
    localparam int S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((ROW_W + DATA_W + 7) / 8) * 8;

    localparam int APB_AW = 3;

    localparam logic [DATA_W-1:0] ALPHA_RESET = DATA_W'(32'h0100_0000);
    localparam logic [DATA_W-1:0] BETA_RESET  = '0;

    localparam logic [0:0] REG_ALPHA = 1'b0;
    localparam logic [0:0] REG_BETA  = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_NZ    = 2'd1,
        FUNC_EMPTY = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NZ_MAG,
        ST_NZ_MUL,
        ST_NZ_SGN,
        ST_NZ_ACC,
        ST_E_MAG,
        ST_E_LO,
        ST_E_HI,
        ST_E_T1,
        ST_E_N1,
        ST_E_T2,
        ST_E_ADD,
        ST_E_OUT
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] alpha;
        logic [DATA_W-1:0] beta;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [VEC_AW-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

endpackage

@@ rtl/csrspmv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module csrspmv_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/csrspmv_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_regs
// APB configuration registers: alpha and beta gains.
// ----------------------------------------------------------------------------
module csrspmv_regs
    import csrspmv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [DATA_W-1:0] alpha_reg;
    logic [DATA_W-1:0] beta_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_ALPHA: alpha_reg <= pwdata;
                REG_BETA:  beta_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ALPHA: prdata = alpha_reg;
            REG_BETA:  prdata = beta_reg;
            default:   prdata = '0;
        endcase
    end

    assign cfg.alpha = alpha_reg;
    assign cfg.beta  = beta_reg;

endmodule

@@ rtl/csrspmv_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_core
// Sequencer and datapath: vector store access, shared 32x32 multiplier,
// saturating accumulate and row output scaling.
// ----------------------------------------------------------------------------
module csrspmv_core
    import csrspmv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic [FUNC_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output ram_req_t             ram_req,
    input  logic [DATA_W-1:0]    ram_rdata
);

    localparam int SHL    = DATA_W - FRAC_BITS;
    localparam int HI_LIM = ACC_W - 1 - SHL;

    localparam logic [ACC_W-1:0] NEG_LIMIT = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] POS_LIMIT = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] OUT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] OUT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [ACC_W-1:0] abs64(input logic [ACC_W-1:0] a);
        abs64 = a[ACC_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] a);
        abs32 = a[DATA_W-1] ? (~a + 1'b1) : a;
    endfunction

    // {overflow, saturated sum}
    function automatic logic [ACC_W:0] add_sat(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        logic             ovf;
        s   = a + b;
        ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
        if (ovf) begin
            add_sat = {1'b1, (a[ACC_W-1] ? NEG_LIMIT : POS_LIMIT)};
        end else begin
            add_sat = {1'b0, s};
        end
    endfunction

    state_t state_reg, state_next;

    logic [POS_W-1:0]  s_pos;
    logic [DATA_W-1:0] s_value;
    logic [DATA_W-1:0] s_old;
    logic              s_in_range;
    logic              accept;
    logic              out_load;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] old_reg;
    logic              in_range_reg;
    logic              rowend_reg;
    logic [ACC_W-1:0]  mag_a_reg;
    logic [DATA_W-1:0] mag_b_reg;
    logic [DATA_W-1:0] mag_c_reg;
    logic [DATA_W-1:0] mag_d_reg;
    logic              neg1_reg;
    logic              neg2_reg;
    logic [ACC_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  lo_reg;
    logic [ACC_W-1:0]  hi_reg;
    logic [ACC_W-1:0]  r_reg;
    logic [ACC_W-1:0]  term_reg;
    logic [ACC_W-1:0]  t1_reg;
    logic [ACC_W-1:0]  t2_reg;
    logic [ACC_W-1:0]  row_sum_reg;
    logic [DATA_W-1:0] res_reg;
    logic              sat_reg;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic              m_valid_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [DATA_W-1:0] m_out_reg;
    logic              m_sat_reg;

    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [ACC_W-1:0]  mul_p;
    logic [DATA_W-1:0] entry;
    logic [ACC_W-1:0]  r_calc;
    logic [ACC_W-1:0]  r_limit;
    logic [ACC_W-1:0]  shifted;
    logic [ACC_W:0]    acc_add;
    logic [ACC_W:0]    out_add;

    assign s_pos      = s_tdata[POS_W-1:0];
    assign s_value    = s_tdata[VAL_LSB +: DATA_W];
    assign s_old      = s_tdata[OLD_LSB +: DATA_W];
    assign s_in_range = 32'(s_pos) < 32'(VEC_DEPTH);
    assign accept     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.re    = 1'b0;
        ram_req.addr  = VEC_AW'(s_pos);
        ram_req.wdata = s_value;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        FUNC_LOAD: ram_req.we = s_in_range;
                        FUNC_NZ: begin
                            ram_req.re = s_in_range;
                            state_next = ST_NZ_MAG;
                        end
                        FUNC_EMPTY: state_next = ST_E_MAG;
                        default:    ;
                    endcase
                end
            end
            ST_NZ_MAG: state_next = ST_NZ_MUL;
            ST_NZ_MUL: state_next = ST_NZ_SGN;
            ST_NZ_SGN: state_next = ST_NZ_ACC;
            ST_NZ_ACC: state_next = rowend_reg ? ST_E_MAG : ST_IDLE;
            ST_E_MAG:  state_next = ST_E_LO;
            ST_E_LO:   state_next = ST_E_HI;
            ST_E_HI:   state_next = ST_E_T1;
            ST_E_T1:   state_next = ST_E_N1;
            ST_E_N1:   state_next = ST_E_T2;
            ST_E_T2:   state_next = ST_E_ADD;
            ST_E_ADD:  state_next = ST_E_OUT;
            ST_E_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_E_HI: begin
                mul_a = mag_a_reg[ACC_W-1:DATA_W];
                mul_b = mag_b_reg;
            end
            ST_E_N1: begin
                mul_a = mag_c_reg;
                mul_b = mag_d_reg;
            end
            default: begin
                mul_a = mag_a_reg[DATA_W-1:0];
                mul_b = mag_b_reg;
            end
        endcase
    end

    assign mul_p   = {{(ACC_W-DATA_W){1'b0}}, mul_a} * {{(ACC_W-DATA_W){1'b0}}, mul_b};
    assign entry   = in_range_reg ? ram_rdata : '0;
    assign r_calc  = (hi_reg << SHL) + (lo_reg >> FRAC_BITS);
    assign r_limit = neg1_reg ? NEG_LIMIT : POS_LIMIT;
    assign shifted = prod_reg >> FRAC_BITS;
    assign acc_add = add_sat(row_sum_reg, term_reg);
    assign out_add = add_sat(t1_reg, t2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg <= '0;
            row_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && (s_tuser == FUNC_EMPTY)) begin
                row_sum_reg <= '0;
            end else if (state_reg == ST_NZ_ACC) begin
                row_sum_reg <= acc_add[ACC_W-1:0];
            end else if (state_reg == ST_E_MAG) begin
                row_sum_reg <= '0;
            end
            if (out_load) begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg    <= s_value;
            old_reg      <= s_old;
            in_range_reg <= s_in_range;
            rowend_reg   <= s_tlast;
        end
        case (state_reg)
            ST_NZ_MAG: begin
                mag_a_reg <= {{(ACC_W-DATA_W){1'b0}}, abs32(value_reg)};
                mag_b_reg <= abs32(entry);
                neg1_reg  <= value_reg[DATA_W-1] ^ entry[DATA_W-1];
            end
            ST_NZ_MUL: prod_reg <= mul_p;
            ST_NZ_SGN: term_reg <= neg1_reg ? (~shifted + 1'b1) : shifted;
            ST_E_MAG: begin
                mag_a_reg <= abs64(row_sum_reg);
                mag_b_reg <= abs32(cfg.alpha);
                neg1_reg  <= row_sum_reg[ACC_W-1] ^ cfg.alpha[DATA_W-1];
                mag_c_reg <= abs32(old_reg);
                mag_d_reg <= abs32(cfg.beta);
                neg2_reg  <= old_reg[DATA_W-1] ^ cfg.beta[DATA_W-1];
                sat_reg   <= 1'b0;
            end
            ST_E_LO: lo_reg <= mul_p;
            ST_E_HI: hi_reg <= mul_p;
            ST_E_T1: begin
                if ((|hi_reg[ACC_W-1:HI_LIM]) || (r_calc > r_limit)) begin
                    r_reg   <= r_limit;
                    sat_reg <= 1'b1;
                end else begin
                    r_reg <= r_calc;
                end
            end
            ST_E_N1: begin
                t1_reg   <= neg1_reg ? (~r_reg + 1'b1) : r_reg;
                prod_reg <= mul_p;
            end
            ST_E_T2: t2_reg <= neg2_reg ? (~shifted + 1'b1) : shifted;
            ST_E_ADD: begin
                if (out_add[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){out_add[ACC_W-1]}}) begin
                    res_reg <= out_add[DATA_W-1:0];
                    sat_reg <= sat_reg | out_add[ACC_W];
                end else begin
                    res_reg <= out_add[ACC_W-1] ? OUT_MIN : OUT_MAX;
                    sat_reg <= 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_row_reg <= row_cnt_reg;
            m_out_reg <= res_reg;
            m_sat_reg <= sat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_out_reg, m_row_reg});
    assign m_tuser  = m_sat_reg;

endmodule

@@ rtl/csr_sparse_matrix_vector_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_update
// Scaled CSR sparse matrix-vector update, out = alpha*A*in + beta*out, Q8.24.
//
//  Port group | Direction | Transaction
//  -----------+-----------+-----------------------------------------------
//  s_*        | in        | vector load, matrix nonzero or empty row item
//  m_*        | out       | finished row: number, scaled value, clip flag
//  p*         | in/out    | APB writes/reads of alpha_gain, beta_gain
//
// Items are taken only while the sequencer is idle. One shared 32x32
// multiplier serves in turn the entry product, the two partial products
// of alpha*sum and the beta*old product. Vector store reads are registered.
// Synchronous active-low reset clears the sequencer, row sum and row
// counter and output valid; the store keeps contents.
// A stalled result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_update
    import csrspmv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // position, value, old_out, zero pad
    input  logic                 s_tlast,  // row_end
    input  logic [FUNC_W-1:0]    s_tuser,  // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // row_number, row_out
    output logic                 m_tuser,  // saturated
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    cfg_t              cfg;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    csrspmv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csrspmv_ram #(
        .DEPTH (VEC_DEPTH),
        .WIDTH (DATA_W),
        .AW    (VEC_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    csrspmv_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

@@ rtl/csrspmv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_checker
// Port-level assertions for the CSR sparse matrix-vector update block.
// ----------------------------------------------------------------------------
module csrspmv_checker
    import csrspmv_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // consecutive results carry consecutive row numbers
    a_row_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=>
            !m_tvalid || (m_tdata[ROW_W-1:0] == ROW_W'($past(m_tdata[ROW_W-1:0]) + 1'b1)))
        else $error("row number out of sequence");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("vector load produced a result");

endmodule

bind csr_sparse_matrix_vector_update csrspmv_checker u_chk (.*);
